// ----- hw/rtl/ratio_test_match_filter_macros.svh -----
// Assertion macros shared by the ratio test match filter RTL.
`ifndef RATIO_TEST_MATCH_FILTER_MACROS_SVH
`define RATIO_TEST_MATCH_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define RTMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtmf assertion failed");
// Next-cycle implication, disabled during reset.
`define RTMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtmf assertion failed");
`else
`define RTMF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTMF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/rtmf_pkg.sv -----
// Types and constants of the ratio test match filter.
package rtmf_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int LEN_W       = 11;
    localparam int DIST_W      = 10;
    localparam int IMG_W       = 8;
    localparam int PT_W        = 12;
    localparam int RATIO_W     = 5;
    localparam int VERDICT_W   = 3;
    localparam int PROD_W      = DIST_W + RATIO_W;
    localparam int RATIO_SCALE = 20;
    localparam int ENTRY_W     = 2 * PT_W + IMG_W;

    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED  = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_MATCH  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_RATIO     = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_FULL      = 3'd4;

    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_ONE  = 2'd1;

    typedef struct packed {
        logic              first_of_set;
        logic [1:0]        match_count;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
        logic [IMG_W-1:0]  best_image;
        logic [IMG_W-1:0]  second_image;
        logic [PT_W-1:0]   query_point;
        logic [PT_W-1:0]   train_point;
    } item_t;

    typedef struct packed {
        logic                 accepted;
        logic [VERDICT_W-1:0] verdict;
        logic [PT_W-1:0]      out_query_point;
        logic [PT_W-1:0]      out_train_point;
        logic [IMG_W-1:0]     out_image;
        logic [LEN_W-1:0]     list_length;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic multi;
        logic ratio_ok;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/ratio_test_match_filter.sv -----
// Top level of the ratio test match filter: stream ports, register port, sequencer and datapath.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | one nearest-neighbour result per transfer
//  m_*     | out | m_tvalid/m_tready  | one verdict per input transfer
//  apb     | in  | psel/penable       | ratio_other_image @0x0, ratio_same_image @0x4
//
// A pair that passes the ratio test goes through accept, check, a scan of the accepted
// list for duplicates through the registered read port, and finish. A duplicate hit
// ends the scan early. Items with no match, a lone match or a failed ratio skip the
// scan. The finish state repeats while the previous verdict waits on m_tready.
// One item is in work at a time; the result register lets the next item be
// accepted while the previous verdict waits on m_tready.
// Reset empties the list (count to zero) and loads ratios 15 and 17.
module ratio_test_match_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] match_count, [11:2] best_distance, [21:12] second_distance,
    // [29:22] best_image, [37:30] second_image, [49:38] query_point,
    // [61:50] train_point, [63:62] zero
    input  logic [63:0] s_tdata,
    // [0] first_of_set
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] out_query_point, [23:12] out_train_point, [31:24] out_image,
    // [42:32] list_length, [47:43] zero
    output logic [47:0] m_tdata,
    // [0] accepted, [3:1] verdict
    output logic [3:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rtmf_pkg::*;

    localparam logic [RATIO_W-1:0] RATIO_OTHER_RST = 5'd15;
    localparam logic [RATIO_W-1:0] RATIO_SAME_RST  = 5'd17;
    localparam logic               REG_OTHER       = 1'b0;
    localparam logic               REG_SAME        = 1'b1;

    logic [RATIO_W-1:0] ratio_other_reg;
    logic [RATIO_W-1:0] ratio_same_reg;
    logic               cfg_write;
    item_t              item;
    ctrl_cmd_t          cmd;
    dp_status_t         status;
    result_t            result;

    // register port: no wait states, address bit 2 picks the register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_SAME) ? 32'(ratio_same_reg) : 32'(ratio_other_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_other_reg <= RATIO_OTHER_RST;
            ratio_same_reg  <= RATIO_SAME_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_OTHER)
                ratio_other_reg <= pwdata[RATIO_W-1:0];
            else
                ratio_same_reg <= pwdata[RATIO_W-1:0];
        end
    end

    // unpack the input transfer
    always_comb
    begin
        item.first_of_set    = s_tuser;
        item.match_count     = s_tdata[1:0];
        item.best_distance   = s_tdata[11:2];
        item.second_distance = s_tdata[21:12];
        item.best_image      = s_tdata[29:22];
        item.second_image    = s_tdata[37:30];
        item.query_point     = s_tdata[49:38];
        item.train_point     = s_tdata[61:50];
    end

    rtmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtmf_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .item_in           (item),
        .ratio_other_image (ratio_other_reg),
        .ratio_same_image  (ratio_same_reg),
        .m_tready          (m_tready),
        .out_valid         (m_tvalid),
        .result            (result)
    );

    // pack the result transfer
    assign m_tdata = {5'b0, result.list_length, result.out_image,
                      result.out_train_point, result.out_query_point};
    assign m_tuser = {result.verdict, result.accepted};

endmodule

// ----- hw/rtl/rtmf_ctrl.sv -----
// Sequencer of the ratio test match filter: load, check, scan, finish.
module rtmf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                in_ready,
    input  rtmf_pkg::dp_status_t status,
    output rtmf_pkg::ctrl_cmd_t  cmd
);
    import rtmf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // only a passing multi-match needs the list scan
                if (status.multi && status.ratio_ok)
                    state_next = ST_SCAN;
                else
                    state_next = ST_FINISH;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`include "ratio_test_match_filter_macros.svh"

    `RTMF_ASSERT_NXT(a_scan_ends, clk, rst_n, (state_reg == ST_SCAN) && status.scan_done, state_reg == ST_FINISH)
    `RTMF_ASSERT_IMP(a_commit_free, clk, rst_n, cmd.commit, status.out_free)
    `RTMF_ASSERT_NXT(a_load_leaves, clk, rst_n, cmd.load, !in_ready)

endmodule

// ----- hw/rtl/rtmf_dp.sv -----
// Datapath: item register, ratio test, accepted list memory, scan and result register.
module rtmf_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rtmf_pkg::ctrl_cmd_t                cmd,
    output rtmf_pkg::dp_status_t               status,
    input  rtmf_pkg::item_t                    item_in,
    input  logic [rtmf_pkg::RATIO_W-1:0]       ratio_other_image,
    input  logic [rtmf_pkg::RATIO_W-1:0]       ratio_same_image,
    input  logic                               m_tready,
    output logic                               out_valid,
    output rtmf_pkg::result_t                  result
);
    import rtmf_pkg::*;

    item_t              item_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic               pend_reg;
    logic               dup_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    logic [ENTRY_W-1:0] mem [LIST_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [RATIO_W-1:0]   ratio;
    logic [PROD_W-1:0]    lhs;
    logic [PROD_W-1:0]    rhs;
    logic                 ratio_ok;
    logic                 multi;
    logic                 lone;
    logic                 issue;
    logic                 hit;
    logic                 full;
    logic                 want_append;
    logic                 append_ok;
    logic [VERDICT_W-1:0] verdict;
    logic [CNT_W-1:0]     count_after;
    logic [ENTRY_W-1:0]   entry;
    logic [PT_W-1:0]      rd_qp;
    logic [PT_W-1:0]      rd_tp;
    logic [IMG_W-1:0]     rd_img;

    always_comb
    begin
        ratio = (item_reg.best_image == item_reg.second_image) ?
                ratio_same_image : ratio_other_image;
        lhs      = PROD_W'(item_reg.best_distance) * PROD_W'(RATIO_SCALE);
        rhs      = PROD_W'(ratio) * PROD_W'(item_reg.second_distance);
        ratio_ok = (lhs < rhs);
        multi    = item_reg.match_count[1];
        lone     = (item_reg.match_count == MATCH_ONE);

        // entry layout: query | train | image
        {rd_qp, rd_tp, rd_img} = rd_data_reg;
        issue = cmd.scan_en && !dup_reg && (scan_idx_reg < count_reg);
        hit   = pend_reg && ((rd_qp == item_reg.query_point) ||
                ((rd_tp == item_reg.train_point) && (rd_img == item_reg.best_image)));

        full        = (count_reg == CNT_W'(LIST_DEPTH));
        want_append = lone || (multi && ratio_ok && !dup_reg);
        append_ok   = want_append && !full;

        priority if (item_reg.match_count == MATCH_NONE)
            verdict = VERDICT_NO_MATCH;
        else if (multi && !ratio_ok)
            verdict = VERDICT_RATIO;
        else if (multi && dup_reg)
            verdict = VERDICT_DUPLICATE;
        else if (full)
            verdict = VERDICT_FULL;
        else
            verdict = VERDICT_ACCEPTED;

        count_after = append_ok ? (count_reg + 1'b1) : count_reg;
        entry       = {item_reg.query_point, item_reg.train_point, item_reg.best_image};

        status.multi     = multi;
        status.ratio_ok  = ratio_ok;
        status.scan_done = !pend_reg && (dup_reg || (scan_idx_reg >= count_reg));
        status.out_free  = !out_valid_reg || m_tready;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        if (cmd.commit)
        begin
            result_reg.accepted        <= append_ok;
            result_reg.verdict         <= verdict;
            result_reg.out_query_point <= item_reg.query_point;
            result_reg.out_train_point <= item_reg.train_point;
            result_reg.out_image       <= item_reg.best_image;
            result_reg.list_length     <= LEN_W'(count_after);
        end
    end

    // list memory: one write port at the tail, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.commit && append_ok)
            mem[count_reg[IDX_W-1:0]] <= entry;
        if (issue)
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            dup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (item_in.first_of_set)
                    count_reg <= '0;
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
                dup_reg      <= 1'b0;
            end
            else
            begin
                pend_reg <= issue;
                if (issue)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (hit)
                    dup_reg <= 1'b1;
                if (cmd.commit && append_ok)
                    count_reg <= count_reg + 1'b1;
            end

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

`include "ratio_test_match_filter_macros.svh"

    `RTMF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(LIST_DEPTH))
    `RTMF_ASSERT_NXT(a_count_step, clk, rst_n, cmd.commit && append_ok, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `RTMF_ASSERT_IMP(a_accept_code, clk, rst_n, out_valid_reg, result_reg.accepted == (result_reg.verdict == VERDICT_ACCEPTED))

endmodule

// ----- bench/match_verdict_checker.sv -----
// Scoreboard for the ratio test match filter: predicts each verdict and compares it.
module match_verdict_checker
    import rtmf_pkg::*;
#(
    parameter logic [2:0] OTHER_ADDR = 3'd0,
    parameter logic [2:0] SAME_ADDR  = 3'd4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          accepted_seen,
    output int          ratio_fail_seen,
    output int          duplicate_seen,
    output int          full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // mirror of the accepted list and the two thresholds
    logic [PT_W-1:0]    held_query [LIST_DEPTH];
    logic [PT_W-1:0]    held_train [LIST_DEPTH];
    logic [IMG_W-1:0]   held_image [LIST_DEPTH];
    int                 held_count;
    logic [RATIO_W-1:0] ratio_other;
    logic [RATIO_W-1:0] ratio_same;

    result_t verdicts_due [$];

    function automatic result_t judge_match(input item_t it);
        result_t            r;
        logic [RATIO_W-1:0] ratio;
        logic               wants_slot;
        logic               clash;
        int                 k;
        r.accepted        = 1'b0;
        r.verdict         = VERDICT_ACCEPTED;
        r.out_query_point = it.query_point;
        r.out_train_point = it.train_point;
        r.out_image       = it.best_image;
        wants_slot        = 1'b0;
        if (it.first_of_set)
            held_count = 0;
        if (it.match_count == MATCH_NONE)
            r.verdict = VERDICT_NO_MATCH;
        else if (it.match_count == MATCH_ONE)
            wants_slot = 1'b1;
        else
        begin
            ratio = (it.best_image == it.second_image) ? ratio_same : ratio_other;
            if (int'(it.best_distance) * RATIO_SCALE >=
                int'(ratio) * int'(it.second_distance))
                r.verdict = VERDICT_RATIO;
            else
            begin
                clash = 1'b0;
                for (k = 0; k < held_count; k++)
                    if (held_query[k] == it.query_point ||
                        (held_train[k] == it.train_point && held_image[k] == it.best_image))
                        clash = 1'b1;
                if (clash)
                    r.verdict = VERDICT_DUPLICATE;
                else
                    wants_slot = 1'b1;
            end
        end
        if (wants_slot)
        begin
            if (held_count >= LIST_DEPTH)
                r.verdict = VERDICT_FULL;
            else
            begin
                held_query[held_count] = it.query_point;
                held_train[held_count] = it.train_point;
                held_image[held_count] = it.best_image;
                held_count++;
                r.accepted = 1'b1;
            end
        end
        r.list_length = LEN_W'(held_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t got;
        result_t want;
        result_t due;
        if (!rst_n)
        begin
            held_count  = 0;
            ratio_other = RATIO_W'(15);
            ratio_same  = RATIO_W'(17);
            verdicts_due.delete();
            fail_count      = 0;
            accepted_seen   = 0;
            ratio_fail_seen = 0;
            duplicate_seen  = 0;
            full_seen       = 0;
        end
        else
        begin
            // output side first: its transfer always belongs to an older item
            if (m_tvalid && m_tready)
            begin
                got.accepted        = m_tuser[0];
                got.verdict         = m_tuser[3:1];
                got.out_query_point = m_tdata[11:0];
                got.out_train_point = m_tdata[23:12];
                got.out_image       = m_tdata[31:24];
                got.list_length     = m_tdata[42:32];
                if (verdicts_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected verdict transfer acc=%0d v=%0d q=%0d",
                                 $realtime, got.accepted, got.verdict, got.out_query_point);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    case (want.verdict)
                        VERDICT_ACCEPTED:  accepted_seen++;
                        VERDICT_RATIO:     ratio_fail_seen++;
                        VERDICT_DUPLICATE: duplicate_seen++;
                        VERDICT_FULL:      full_seen++;
                        default:           ;
                    endcase
                    if (got.accepted !== want.accepted ||
                        got.verdict !== want.verdict ||
                        got.out_query_point !== want.out_query_point ||
                        got.out_train_point !== want.out_train_point ||
                        got.out_image !== want.out_image ||
                        got.list_length !== want.list_length)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("%0t: verdict mismatch", $realtime);
                            $display("  expected acc=%0d v=%0d q=%0d t=%0d img=%0d len=%0d",
                                     want.accepted, want.verdict, want.out_query_point,
                                     want.out_train_point, want.out_image, want.list_length);
                            $display("  actual   acc=%0d v=%0d q=%0d t=%0d img=%0d len=%0d",
                                     got.accepted, got.verdict, got.out_query_point,
                                     got.out_train_point, got.out_image, got.list_length);
                        end
                    end
                end
            end
            // register writes; the bench only drives the two register addresses
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == OTHER_ADDR)
                    ratio_other = pwdata[RATIO_W-1:0];
                else if (paddr == SAME_ADDR)
                    ratio_same = pwdata[RATIO_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                it.first_of_set    = s_tuser;
                it.match_count     = s_tdata[1:0];
                it.best_distance   = s_tdata[11:2];
                it.second_distance = s_tdata[21:12];
                it.best_image      = s_tdata[29:22];
                it.second_image    = s_tdata[37:30];
                it.query_point     = s_tdata[49:38];
                it.train_point     = s_tdata[61:50];
                due                = judge_match(it);
                verdicts_due       = {verdicts_due, due};
            end
        end
        pending = verdicts_due.size();
    end

endmodule

// ----- bench/tb_ratio_test_match_filter.sv -----
// Testbench top of the ratio test match filter: clock, reset, stimulus and verdict.
module tb_ratio_test_match_filter;
    import rtmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // register map: ratio_other_image at 0x0, ratio_same_image at 0x4
    localparam logic [2:0] ADDR_RATIO_OTHER = 3'd0;
    localparam logic [2:0] ADDR_RATIO_SAME  = 3'd4;

    // match counts the package leaves unnamed; three counts as two or more
    localparam logic [1:0] MATCH_TWO   = 2'd2;
    localparam logic [1:0] MATCH_THREE = 2'd3;

    // random part: five short-set phases and one phase that fills the list
    localparam int PHASES       = 6;
    localparam int FILL_PHASE   = 2;
    localparam int HOLD_PHASE   = 1;
    localparam int PHASE_ITEMS  = 55;
    localparam int FILL_ITEMS   = LIST_DEPTH + 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    // Worst case per item: a full-list scan plus a random gap on each side, over
    // about 1450 items. The limit takes that worst case about five times over.
    localparam int CYCLE_LIMIT = 8_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // match_count, best/second distance, best/second image, q, t
    logic        s_tuser;   // [0] first_of_set
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_query_point, out_train_point, out_image, list_length
    logic [3:0]  m_tuser;   // [0] accepted, [3:1] verdict
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int accepted_seen;
    int ratio_fail_seen;
    int duplicate_seen;
    int full_seen;

    int cycle_count;
    int items_sent;
    int settings_used;
    bit calm;       // set for the last part: no idling on either side
    bit hold_req;   // asks the receiver for one long hold-off

    ratio_test_match_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    match_verdict_checker #(
        .OTHER_ADDR (ADDR_RATIO_OTHER),
        .SAME_ADDR  (ADDR_RATIO_SAME)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .pending         (pending),
        .accepted_seen   (accepted_seen),
        .ratio_fail_seen (ratio_fail_seen),
        .duplicate_seen  (duplicate_seen),
        .full_seen       (full_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_ratio_test_match_filter: done, errors");
            $finish;
        end
    end

    // Build one item from its fields.
    function automatic item_t mk(input logic first, input logic [1:0] count,
                                 input int best, input int second,
                                 input int bimg, input int simg,
                                 input int qp, input int tp);
        item_t it;
        it.first_of_set    = first;
        it.match_count     = count;
        it.best_distance   = DIST_W'(best);
        it.second_distance = DIST_W'(second);
        it.best_image      = IMG_W'(bimg);
        it.second_image    = IMG_W'(simg);
        it.query_point     = PT_W'(qp);
        it.train_point     = PT_W'(tp);
        return it;
    endfunction

    // Mostly well-formed items with random content; one in ten is raw noise over
    // the full width of every field. lone_pct sets the share of lone matches.
    function automatic item_t random_item(input logic first, input int lone_pct);
        int roll;
        int second;
        int bimg;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return mk(first, 2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 4095),
                      $urandom_range(0, 4095));
        second = $urandom_range(1, 1023);
        bimg   = $urandom_range(0, 3);
        roll   = $urandom_range(0, 99);
        // small index pools make duplicate hits common in short sets
        return mk(first,
                  (roll < lone_pct) ? MATCH_ONE :
                  (roll < lone_pct + 5) ? MATCH_NONE :
                  (roll < lone_pct + 15) ? MATCH_THREE : MATCH_TWO,
                  $urandom_range(0, second), second, bimg,
                  $urandom_range(0, 1) ? bimg : $urandom_range(0, 255),
                  $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 4095),
                  $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 4095));
    endfunction

    // Offer one item, called at a falling edge. tvalid stays high on return so
    // back-to-back items need no gap; whoever pauses afterwards lowers it.
    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.first_of_set;
        s_tdata  = {2'b00, it.train_point, it.query_point, it.second_image,
                    it.best_image, it.second_distance, it.best_distance,
                    it.match_count};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Register write: setup phase, then access phase until pready.
    // Upper data bits carry junk; only the low five bits are kept.
    task automatic write_reg(input logic [2:0] addr, input logic [RATIO_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = ($urandom & ~32'h1F) | 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Thresholds change only with the block idle: every verdict back first.
    // Each item yields exactly one verdict, so nothing is left in work then.
    task automatic set_ratios(input logic [RATIO_W-1:0] other,
                              input logic [RATIO_W-1:0] same);
        s_tvalid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
        write_reg(ADDR_RATIO_OTHER, other);
        write_reg(ADDR_RATIO_SAME, same);
        settings_used++;
    endtask

    // Receiver: random stall bursts, ready stretches of varied length, and one
    // long hold-off on request so the block backs up and stalls its input.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(60, 120)) @(negedge clk);
                else
                    repeat ($urandom_range(0, 24)) @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cycle_count   = 0;
        items_sent    = 0;
        settings_used = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part, reset thresholds (other 15, same 17) ----
        // no match with every field at its top value
        send_item(mk(1'b1, MATCH_NONE, 1023, 1023, 255, 255, 4095, 4095));
        // lone matches go in unchecked, even a repeated one
        send_item(mk(1'b0, MATCH_ONE, 0, 0, 0, 0, 0, 0));
        send_item(mk(1'b0, MATCH_ONE, 0, 0, 0, 0, 0, 0));
        // clear pass, then duplicate on query point, then on train point and image
        send_item(mk(1'b0, MATCH_TWO, 10, 100, 1, 2, 5, 7));
        send_item(mk(1'b0, MATCH_TWO, 10, 100, 3, 2, 5, 8));
        send_item(mk(1'b0, MATCH_TWO, 10, 100, 1, 2, 6, 7));
        // same train point in another image is no duplicate
        send_item(mk(1'b0, MATCH_TWO, 10, 100, 2, 3, 6, 7));
        // zero second distance rejects
        send_item(mk(1'b0, MATCH_TWO, 0, 0, 8, 9, 40, 40));
        // a count of three behaves as two or more
        send_item(mk(1'b0, MATCH_THREE, 1, 2, 4, 5, 9, 9));
        // threshold edge with neighbours in different images: equal fails
        send_item(mk(1'b0, MATCH_TWO, 15, 20, 1, 2, 10, 10));
        send_item(mk(1'b0, MATCH_TWO, 14, 20, 1, 2, 10, 10));
        // threshold edge with both neighbours in one image
        send_item(mk(1'b0, MATCH_TWO, 17, 20, 6, 6, 11, 11));
        send_item(mk(1'b0, MATCH_TWO, 16, 20, 6, 6, 11, 11));
        // distance extremes
        send_item(mk(1'b0, MATCH_TWO, 1023, 1023, 255, 255, 4095, 4095));
        send_item(mk(1'b0, MATCH_TWO, 0, 1023, 255, 0, 4095, 4095));
        // first of a new set empties the list: an old duplicate now passes
        send_item(mk(1'b1, MATCH_TWO, 10, 100, 1, 2, 5, 7));

        // zero thresholds: no pair can pass, a lone match still can
        set_ratios(RATIO_W'(0), RATIO_W'(0));
        send_item(mk(1'b0, MATCH_TWO, 0, 1023, 1, 2, 100, 100));
        send_item(mk(1'b0, MATCH_ONE, 0, 1023, 1, 2, 100, 100));
        // thresholds above twenty are used as given
        set_ratios(RATIO_W'(31), RATIO_W'(31));
        send_item(mk(1'b0, MATCH_TWO, 30, 20, 7, 7, 200, 200));
        send_item(mk(1'b0, MATCH_TWO, 31, 20, 7, 7, 201, 201));
        // unity ratio
        set_ratios(RATIO_W'(20), RATIO_W'(20));
        send_item(mk(1'b0, MATCH_TWO, 1022, 1023, 9, 10, 300, 300));
        send_item(mk(1'b0, MATCH_TWO, 1023, 1023, 9, 10, 301, 301));

        // ---- random part ----
        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            case (p)
                0:       set_ratios(RATIO_W'(15), RATIO_W'(17));
                1:       set_ratios(RATIO_W'(20), RATIO_W'(20));
                2:       set_ratios(RATIO_W'(12), RATIO_W'(16));
                3:       set_ratios(RATIO_W'(31), RATIO_W'(25));
                4:       set_ratios(RATIO_W'(0), RATIO_W'(20));
                default: set_ratios(RATIO_W'($urandom_range(0, 31)),
                                    RATIO_W'($urandom_range(0, 31)));
            endcase
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            if (p == FILL_PHASE)
            begin
                // one long set: lone matches fill every slot, then random items
                // meet the full list
                for (int n = 0; n < FILL_ITEMS; n++)
                    if (n < LIST_DEPTH)
                        send_item(mk(n == 0, MATCH_ONE, $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 255),
                                     $urandom_range(0, 255), $urandom_range(0, 4095),
                                     $urandom_range(0, 4095)));
                    else
                        send_item(random_item(1'b0, 50));
            end
            else
            begin
                for (int sent = 0; sent < PHASE_ITEMS; )
                begin
                    int len;
                    len = $urandom_range(1, 40);
                    for (int n = 0; n < len; n++)
                        send_item(random_item(n == 0, 20));
                    sent += len;
                end
            end
        end

        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d transfers under %0d threshold settings",
                 items_sent, settings_used);
        $display("verdicts: %0d accepted, %0d ratio fails, %0d duplicates, %0d list full",
                 accepted_seen, ratio_fail_seen, duplicate_seen, full_seen);
        if (fail_count == 0)
            $display("tb_ratio_test_match_filter: done, clean");
        else
            $display("tb_ratio_test_match_filter: done, errors");
        $finish;
    end

endmodule
